>>> rtl/ttlexp_pkg.sv
`default_nettype none

package ttlexp_pkg;

	localparam int KEY_W    = 64;
	localparam int TIME_W   = 32;
	localparam int EXP_W    = TIME_W + 1;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int LIVE_W   = 7;

	localparam logic [TIME_W-1:0] TTL_RESET = 32'd5;
	localparam logic [LIVE_W-1:0] LIVE_MAX  = 7'd127;

	// operation codes
	localparam logic [OP_W-1:0] OP_GENERATE = 2'd0;
	localparam logic [OP_W-1:0] OP_RENEW    = 2'd1;
	localparam logic [OP_W-1:0] OP_COUNT    = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_APPLIED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [KEY_W-1:0]  token_key;
		logic [TIME_W-1:0] current_time;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LIVE_W-1:0]   live_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [EXP_W-1:0] expiry;
	} slot_t;

	// engine status toward the top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} eng_status_t;

endpackage

`default_nettype wire

>>> rtl/ttlexp_engine.sv
`default_nettype none

module ttlexp_engine #(
	parameter int CAPACITY = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  ttlexp_pkg::req_t             req,
	input  wire [ttlexp_pkg::TIME_W-1:0] ttl,
	input  wire                          res_take,
	output ttlexp_pkg::eng_status_t      stat,
	output ttlexp_pkg::rsp_t             res
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SAT_W = (CNT_W > ttlexp_pkg::LIVE_W) ? CNT_W : ttlexp_pkg::LIVE_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// slot store: key and expiry; validity is the prefix below fill_q
	ttlexp_pkg::slot_t mem [CAPACITY];
	ttlexp_pkg::slot_t rd_slot_s1;

	logic [IDX_W-1:0] issue_cnt_q;
	logic             issuing_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic [ttlexp_pkg::OP_W-1:0]   op_q;
	logic [ttlexp_pkg::KEY_W-1:0]  key_q;
	logic [ttlexp_pkg::TIME_W-1:0] now_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] live_q;
	logic             match_found_q;
	logic             match_live_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic slot_vld, slot_live, key_hit, last_rd;

	logic [IDX_W-1:0]                  tgt_idx;
	logic                              do_write;
	logic                              was_live;
	logic [ttlexp_pkg::STATUS_W-1:0]   status;
	logic [CNT_W-1:0]                  live_after;
	logic [SAT_W-1:0]                  live_ext;
	logic [ttlexp_pkg::EXP_W-1:0]      new_expiry;
	logic                              ttl_nz;
	logic                              load;
	logic                              mem_we;
	ttlexp_pkg::slot_t                 wr_slot;

	// per-slot evaluation of the returning read
	always_comb begin
		slot_vld  = CNT_W'(rd_idx_s1) < fill_q;
		slot_live = slot_vld && (rd_slot_s1.expiry > {1'b0, now_q});
		key_hit   = slot_vld && (rd_slot_s1.key == key_q);
		last_rd   = rd_vld_s1 && (rd_idx_s1 == IDX_W'(CAPACITY - 1));
	end

	// decision after the scan
	always_comb begin
		ttl_nz     = ttl != '0;
		new_expiry = {1'b0, now_q} + {1'b0, ttl};
		tgt_idx    = match_idx_q;
		do_write   = 1'b0;
		was_live   = 1'b0;
		status     = ttlexp_pkg::ST_APPLIED;
		case (op_q)
			ttlexp_pkg::OP_GENERATE: begin
				if (match_found_q) begin
					do_write = 1'b1;
					was_live = match_live_q;
				end else if (free_found_q) begin
					tgt_idx  = free_idx_q;
					do_write = 1'b1;
				end else begin
					status = ttlexp_pkg::ST_FULL;
				end
			end
			ttlexp_pkg::OP_RENEW: begin
				if (match_found_q && match_live_q) begin
					do_write = 1'b1;
					was_live = 1'b1;
				end else begin
					status = ttlexp_pkg::ST_IGNORED;
				end
			end
			default: begin
			end
		endcase
		live_after = live_q - CNT_W'(was_live) + CNT_W'(do_write && ttl_nz);
		live_ext   = SAT_W'(live_after);
		wr_slot.key    = key_q;
		wr_slot.expiry = new_expiry;
	end

	assign load   = (state_q == S_DONE) && res_take;
	assign mem_we = load && do_write;

	assign stat.busy      = state_q != S_IDLE;
	assign stat.res_valid = state_q == S_DONE;
	assign res.status     = status;
	assign res.live_count = (live_ext > SAT_W'(ttlexp_pkg::LIVE_MAX)) ?
		ttlexp_pkg::LIVE_MAX : live_ext[ttlexp_pkg::LIVE_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tgt_idx] <= wr_slot;
		end
		if (issuing_q) begin
			rd_slot_s1 <= mem[issue_cnt_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_cnt_q;
		if (start) begin
			op_q  <= req.operation;
			key_q <= req.token_key;
			now_q <= req.current_time;
		end
		if (rd_vld_s1 && key_hit && !match_found_q) begin
			match_idx_q  <= rd_idx_s1;
			match_live_q <= slot_live;
		end
		if (rd_vld_s1 && !slot_live && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			issue_cnt_q   <= '0;
			issuing_q     <= 1'b0;
			rd_vld_s1     <= 1'b0;
			fill_q        <= '0;
			live_q        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issuing_q;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q       <= S_SCAN;
						issue_cnt_q   <= '0;
						issuing_q     <= 1'b1;
						live_q        <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (issuing_q) begin
						issue_cnt_q <= issue_cnt_q + IDX_W'(1);
						if (issue_cnt_q == IDX_W'(CAPACITY - 1)) begin
							issuing_q <= 1'b0;
						end
					end
					if (rd_vld_s1) begin
						if (slot_live) begin
							live_q <= live_q + CNT_W'(1);
						end
						if (key_hit) begin
							match_found_q <= 1'b1;
						end
						if (!slot_live) begin
							free_found_q <= 1'b1;
						end
					end
					if (last_rd) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
						if (mem_we && (CNT_W'(tgt_idx) == fill_q)) begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("item started while busy");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == S_DONE && !issuing_q && !rd_vld_s1)
		else $error("slot write overlaps scan");

	a_read_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == S_SCAN)
		else $error("read data outside scan");

	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("fill count moved by more than one");

endmodule

`default_nettype wire

>>> rtl/token_ttl_expiry_table.sv
// Token expiry table. Holds CAPACITY 64-bit token keys with a 33-bit expiry
// each, in one single-port-read, single-port-write memory. Each accepted item
// (generate, renew or count) is answered with one transfer carrying a status
// and the number of entries whose expiry is after the item's current_time.
// An item passes from its transfer to its result through one accept step,
// CAPACITY memory reads (one slot per cycle), the return of the last read
// and the write-back and result, which waits for the output register. One
// item is in work at a time; req_stall is high from the accept until the
// result has moved into the output register, and a result held there by
// rsp_stall does not block the next item unless it is done.
// Occupied slots always form a prefix tracked by a fill count, so no clearing
// pass is needed after reset. time_to_live resets to 5 and is written through
// the cfg channel, which is always ready; write it only while the block is
// idle. current_time is expected not to decrease between items.
`default_nettype none

module token_ttl_expiry_table #(
	parameter int CAPACITY = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          req_valid,
	output logic                         req_stall,
	input  ttlexp_pkg::req_t             req,

	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output ttlexp_pkg::rsp_t             rsp,

	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [ttlexp_pkg::TIME_W-1:0] cfg_data
);

	logic [ttlexp_pkg::TIME_W-1:0] ttl_q;
	logic                          rsp_valid_q;
	ttlexp_pkg::rsp_t              rsp_q;

	ttlexp_pkg::eng_status_t eng_stat;
	ttlexp_pkg::rsp_t        eng_res;
	logic                    start;
	logic                    res_take;

	// input transfer only while the engine is idle
	assign req_stall = eng_stat.busy;
	assign start     = req_valid && !eng_stat.busy;

	// output register frees up when empty or when its transfer completes
	assign res_take  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	ttlexp_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.ttl      (ttl_q),
		.res_take (res_take),
		.stat     (eng_stat),
		.res      (eng_res)
	);

	always_ff @(posedge clk) begin
		if (eng_stat.res_valid && res_take) begin
			rsp_q <= eng_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q       <= ttlexp_pkg::TTL_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ttl_q <= cfg_data;
			end
			if (res_take) begin
				rsp_valid_q <= eng_stat.res_valid;
			end
		end
	end

endmodule

`default_nettype wire

>>> test/tb_token_ttl_expiry_table.sv
`timescale 1ns / 100ps

module tb_token_ttl_expiry_table;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	// code 3 has no name in the package; the table treats it as a count
	localparam logic [ttlexp_pkg::OP_W-1:0] OP_COUNT_ALT = 2'd3;
	localparam int POOL_SIZE = 80;

	logic clk = 1'b0;
	logic arst_n;

	logic req_valid;
	logic req_stall;
	ttlexp_pkg::req_t req;

	logic rsp_valid;
	logic rsp_stall;
	ttlexp_pkg::rsp_t rsp;

	logic cfg_valid;
	logic cfg_ready;
	logic [ttlexp_pkg::TIME_W-1:0] cfg_data;

	token_ttl_expiry_table #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Table shadow: what the block should hold after each transfer
	// ---------------------------------------------------------------
	logic                          held    [CAPACITY];
	logic [ttlexp_pkg::KEY_W-1:0]  held_key[CAPACITY];
	logic [ttlexp_pkg::EXP_W-1:0]  held_exp[CAPACITY];
	logic [ttlexp_pkg::TIME_W-1:0] lifetime;

	ttlexp_pkg::rsp_t pending_answers[$];

	int n_errors = 0;
	int n_results = 0;
	int n_applied = 0;
	int n_ignored = 0;
	int n_dropped = 0;
	int n_lifetimes = 0;
	int cycle_count = 0;

	int send_pct;
	int recv_pct;
	int hold_left = 0;

	logic [ttlexp_pkg::KEY_W-1:0]  key_pool[POOL_SIZE];
	logic [ttlexp_pkg::TIME_W-1:0] stamp;

	// Applies one operation to the shadow table and returns its answer.
	function automatic ttlexp_pkg::rsp_t apply_token_op(input ttlexp_pkg::req_t r);
		ttlexp_pkg::rsp_t a;
		int slot;
		int live;
		logic [ttlexp_pkg::EXP_W-1:0] now;
		logic [ttlexp_pkg::EXP_W-1:0] new_exp;
		now = {1'b0, r.current_time};
		new_exp = now + {1'b0, lifetime};
		a.status = ttlexp_pkg::ST_APPLIED;
		slot = -1;
		if (r.operation == ttlexp_pkg::OP_GENERATE || r.operation == ttlexp_pkg::OP_RENEW) begin
			for (int i = 0; i < CAPACITY; i++)
				if (slot < 0 && held[i] && held_key[i] == r.token_key)
					slot = i;
		end
		if (r.operation == ttlexp_pkg::OP_GENERATE) begin
			// new key: lowest slot that is empty or already expired
			if (slot < 0)
				for (int i = 0; i < CAPACITY; i++)
					if (slot < 0 && !(held[i] && held_exp[i] > now))
						slot = i;
			if (slot < 0) begin
				a.status = ttlexp_pkg::ST_FULL;
			end else begin
				held[slot] = 1'b1;
				held_key[slot] = r.token_key;
				held_exp[slot] = new_exp;
			end
		end else if (r.operation == ttlexp_pkg::OP_RENEW) begin
			if (slot < 0 || held_exp[slot] <= now)
				a.status = ttlexp_pkg::ST_IGNORED;
			else
				held_exp[slot] = new_exp;
		end
		live = 0;
		for (int i = 0; i < CAPACITY; i++)
			if (held[i] && held_exp[i] > now)
				live++;
		if (live > int'(ttlexp_pkg::LIVE_MAX))
			live = int'(ttlexp_pkg::LIVE_MAX);
		a.live_count = live[ttlexp_pkg::LIVE_W-1:0];
		return a;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch, %s: got %0h, want %0h", $time, what, got, want);
		n_errors++;
	endtask

	// ---------------------------------------------------------------
	// Result side: random stalls, rare long holds, compare in order
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0 && recv_pct > 0
				&& $urandom_range(0, 31) == 0)
			hold_left <= $urandom_range(CAPACITY, 2 * CAPACITY);
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
		rsp_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_pct);
	end

	always @(posedge clk) begin
		ttlexp_pkg::rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			n_results++;
			if (pending_answers.size() == 0) begin
				report_mismatch("result with nothing pending", 64'(rsp), 64'd0);
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.live_count !== want.live_count)
					report_mismatch("live_count", 64'(rsp.live_count),
						64'(want.live_count));
				if (want.status == ttlexp_pkg::ST_APPLIED)
					n_applied++;
				else if (want.status == ttlexp_pkg::ST_IGNORED)
					n_ignored++;
				else
					n_dropped++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout, %0d results still pending", $time,
				pending_answers.size());
			$display("tb_token_ttl_expiry_table NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------
	// One transfer; the typed answer, where given, replaces the shadow's.
	task automatic send_item(input ttlexp_pkg::req_t r, input bit typed,
			input ttlexp_pkg::rsp_t answer);
		ttlexp_pkg::rsp_t predicted;
		int gap;
		gap = (send_pct > 0 && $urandom_range(0, 15) == 0) ?
			$urandom_range(1, CAPACITY + 4) : 0;
		while (gap > 0 || $urandom_range(0, 99) < send_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			if (gap > 0)
				gap--;
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		predicted = apply_token_op(r);
		pending_answers.push_back(typed ? answer : predicted);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lifetime(input logic [ttlexp_pkg::TIME_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		lifetime = v;
		n_lifetimes++;
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Directed steps
	// ---------------------------------------------------------------
	typedef struct {
		bit                            is_cfg;
		logic [ttlexp_pkg::TIME_W-1:0] value;
		ttlexp_pkg::req_t              item;
		bit                            typed;
		ttlexp_pkg::rsp_t              answer;
	} step_t;

	step_t directed_steps[$];

	function automatic void add_lifetime(input logic [ttlexp_pkg::TIME_W-1:0] v);
		step_t s;
		s.is_cfg = 1'b1;
		s.value = v;
		s.item = '0;
		s.typed = 1'b0;
		s.answer = '0;
		directed_steps.push_back(s);
	endfunction

	function automatic void add_op(input logic [ttlexp_pkg::OP_W-1:0] op,
			input logic [ttlexp_pkg::KEY_W-1:0] key,
			input logic [ttlexp_pkg::TIME_W-1:0] t, input bit typed,
			input logic [ttlexp_pkg::STATUS_W-1:0] st,
			input logic [ttlexp_pkg::LIVE_W-1:0] live);
		step_t s;
		s.is_cfg = 1'b0;
		s.value = '0;
		s.item.operation = op;
		s.item.token_key = key;
		s.item.current_time = t;
		s.typed = typed;
		s.answer.status = st;
		s.answer.live_count = live;
		directed_steps.push_back(s);
	endfunction

	// Random items around a moving time stamp; keys mostly from a pool
	// a bit larger than the table so that it can fill up.
	task automatic run_segment(input logic [ttlexp_pkg::TIME_W-1:0] life,
			input logic [ttlexp_pkg::TIME_W-1:0] jump, input int n_items);
		ttlexp_pkg::req_t r;
		int roll;
		write_lifetime(life);
		stamp = stamp + jump;
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 2 && stamp > 16)
				stamp = stamp - $urandom_range(1, 16);  // time stepping back
			else if (roll < 5)
				stamp = stamp + $urandom_range(8, 64);
			else
				stamp = stamp + $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < 50)
				r.operation = ttlexp_pkg::OP_GENERATE;
			else if (roll < 80)
				r.operation = ttlexp_pkg::OP_RENEW;
			else if (roll < 95)
				r.operation = ttlexp_pkg::OP_COUNT;
			else
				r.operation = OP_COUNT_ALT;
			if ($urandom_range(0, 99) < 85)
				r.token_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				r.token_key = {$urandom, $urandom};
			r.current_time = stamp;
			send_item(r, 1'b0, '0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		send_pct = 21;
		recv_pct = 49;
		for (int i = 0; i < CAPACITY; i++)
			held[i] = 1'b0;
		lifetime = ttlexp_pkg::TTL_RESET;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		// lifetime 5 out of reset
		add_op(ttlexp_pkg::OP_COUNT, 64'h0, 32'd0, 1'b1, ttlexp_pkg::ST_APPLIED, 7'd0);
		add_op(ttlexp_pkg::OP_RENEW, 64'h0, 32'd0, 1'b1, ttlexp_pkg::ST_IGNORED, 7'd0);
		add_op(ttlexp_pkg::OP_GENERATE, 64'h0, 32'd0, 1'b1, ttlexp_pkg::ST_APPLIED, 7'd1);
		add_op(ttlexp_pkg::OP_GENERATE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1,
			ttlexp_pkg::ST_APPLIED, 7'd2);
		add_op(ttlexp_pkg::OP_RENEW, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4, 1'b1,
			ttlexp_pkg::ST_APPLIED, 7'd2);
		add_op(OP_COUNT_ALT, 64'h0, 32'd5, 1'b1, ttlexp_pkg::ST_APPLIED, 7'd1);
		// expiry equal to now counts as expired
		add_op(ttlexp_pkg::OP_RENEW, 64'h0, 32'd5, 1'b1, ttlexp_pkg::ST_IGNORED, 7'd1);
		// held but expired key refreshed in place
		add_op(ttlexp_pkg::OP_GENERATE, 64'h0, 32'd5, 1'b0, '0, '0);
		// new key takes the expired slot, old key is gone
		add_op(ttlexp_pkg::OP_GENERATE, 64'h5555_5555_5555_5555, 32'd9, 1'b0, '0, '0);
		add_op(ttlexp_pkg::OP_RENEW, 64'hFFFF_FFFF_FFFF_FFFF, 32'd9, 1'b0, '0, '0);
		add_op(ttlexp_pkg::OP_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFF0, 1'b0,
			'0, '0);
		add_op(ttlexp_pkg::OP_COUNT, 64'h0, 32'hFFFF_FFFF, 1'b0, '0, '0);
		// time going backwards
		add_op(ttlexp_pkg::OP_COUNT, 64'h0, 32'd3, 1'b0, '0, '0);
		add_op(ttlexp_pkg::OP_GENERATE, 64'h8000_0000_0000_0001, 32'h7FFF_FFFF, 1'b0,
			'0, '0);
		// largest lifetime at the largest time: expiry needs the 33rd bit
		add_lifetime(32'hFFFF_FFFF);
		add_op(ttlexp_pkg::OP_GENERATE, 64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF, 1'b0,
			'0, '0);
		add_op(ttlexp_pkg::OP_COUNT, 64'h0, 32'hFFFF_FFFF, 1'b0, '0, '0);
		// zero lifetime: stored, but dead at once
		add_lifetime(32'd0);
		add_op(ttlexp_pkg::OP_GENERATE, 64'hDEAD, 32'h100, 1'b0, '0, '0);
		add_op(ttlexp_pkg::OP_RENEW, 64'hDEAD, 32'h100, 1'b0, '0, '0);
		add_lifetime(32'd1);
		add_op(ttlexp_pkg::OP_GENERATE, 64'hDEAD, 32'h100, 1'b0, '0, '0);
		add_op(ttlexp_pkg::OP_RENEW, 64'hDEAD, 32'h100, 1'b0, '0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[n]) begin
			if (directed_steps[n].is_cfg)
				write_lifetime(directed_steps[n].value);
			else
				send_item(directed_steps[n].item, directed_steps[n].typed,
					directed_steps[n].answer);
		end

		stamp = 32'h200;
		// short lifetimes: steady churn of slots
		run_segment(32'd8, 32'h100, 150);
		run_segment($urandom_range(1, 64), 32'd0, 150);
		// long lifetime fills the table, new keys get dropped
		send_pct = 49;
		recv_pct = 21;
		run_segment(32'd100_000, 32'd0, 150);
		// jump past every expiry, then short lifetimes again
		run_segment($urandom_range(2, 30), 32'd200_000, 150);
		send_pct = 0;
		recv_pct = 0;
		run_segment(ttlexp_pkg::TTL_RESET, 32'd0, 150);
		// near the top of the time range, largest lifetime
		run_segment(32'hFFFF_FFFF, 32'hFFFF_0000 - stamp, 150);

		wait_drained();
		repeat (2 * CAPACITY) @(posedge clk);

		$display("%0d results: %0d applied, %0d renews ignored, %0d generates dropped",
			n_results, n_applied, n_ignored, n_dropped);
		$display("%0d lifetime writes, %0d mismatches, %0d cycles",
			n_lifetimes, n_errors, cycle_count);
		if (n_errors == 0 && pending_answers.size() == 0)
			$display("tb_token_ttl_expiry_table OK");
		else
			$display("tb_token_ttl_expiry_table NOT OK");
		$finish;
	end

endmodule
